/* src/satt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// satt_pkg
// shared types, constants and score helpers of the transposition table core
// ----------------------------------------------------------------------------
package satt_pkg;

    localparam int SET_BITS = 10;
    localparam int WAYS     = 4;
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int SCORE_W     = 16;
    localparam int THR_W       = 15;
    localparam int AGE_W       = 8;
    localparam int S_DATA_W    = 152;
    localparam int M_DATA_W    = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(30000);
    localparam logic signed [17:0] SCORE_MAX = 18'sd32767;
    localparam logic signed [17:0] SCORE_MIN = -18'sd32767;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_PROBE  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    localparam logic REG_MATE_THR = 1'b0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic [AGE_W-1:0]   stamp;
        logic [2:0]         promo;
        logic [5:0]         dest;
        logic [5:0]         src;
        logic               has_move;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic [SCORE_W-1:0] score;
    } payload_t;

    typedef struct packed {
        payload_t    pay;
        logic [63:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int ROW_W   = ENTRY_W * WAYS;

    typedef entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [63:0]               key;
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                bound;
        logic [7:0]                depth;
        logic [7:0]                ply;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic                      has_move;
        logic [5:0]                src;
        logic [5:0]                dest;
        logic [2:0]                promo;
    } item_t;

    typedef struct packed {
        logic [2:0]                move_promotion;
        logic [5:0]                move_dest;
        logic [5:0]                move_src;
        logic signed [SCORE_W-1:0] result_score;
        logic                      found_score;
        logic                      found_move;
        logic                      hit;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // mate distance adjustment by ply, saturated to the legal score range
    // to_root = 1 moves the score toward storage form (insert), 0 back (probe)
    function automatic logic signed [SCORE_W-1:0] mate_adjust(
        input logic signed [SCORE_W-1:0] s,
        input logic [7:0]                ply,
        input logic [THR_W-1:0]          thr,
        input logic                      to_root
    );
        logic signed [17:0] sx;
        logic signed [17:0] mag;
        logic signed [17:0] px;
        logic signed [17:0] r;
        logic               pos;
        sx  = {{2{s[SCORE_W-1]}}, s};
        mag = s[SCORE_W-1] ? -sx : sx;
        px  = $signed({10'b0, ply});
        pos = !s[SCORE_W-1] && (s != '0);
        r   = sx;
        if (mag >= $signed({3'b0, thr})) begin
            if (pos == to_root) begin
                r = sx + px;
            end else begin
                r = sx - px;
            end
        end
        if (r > SCORE_MAX) begin
            r = SCORE_MAX;
        end else if (r < SCORE_MIN) begin
            r = SCORE_MIN;
        end
        return r[SCORE_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* src/set_assoc_transposition_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_transposition_table_core
// set-associative position cache with insert, probe and time tick commands
// ----------------------------------------------------------------------------
//  channel  | ports                       | contents
//  ---------+-----------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata   | command transaction, cmd in tuser
//  result   | m_tvalid m_tready m_tdata   | one result per command
//  config   | psel penable pwrite paddr   | mate_threshold at address 0
//
//  each transaction is a bucket row read, then compare and write-back of the
//  same row; one transaction is in flight at a time
//  after reset a clearing pass writes all 1024 bucket rows with s_tready low;
//  configuration writes are taken during it
//  a stalled result holds the lookup stage until the output register drains
// ----------------------------------------------------------------------------
module set_assoc_transposition_table_core
    import satt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // cmd
    input  wire logic [1:0]            s_tuser,
    // key, score, bound, depth, ply, alpha, beta, has_move, src_square,
    // dest_square, promotion, zero fill
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // hit, found_move, found_score, result_score, move_src, move_dest,
    // move_promotion, zero fill
    output logic [M_DATA_W-1:0]        m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    state_t              state_reg, state_next;
    logic [SET_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [THR_W-1:0]    thr_reg;
    logic [AGE_W-1:0]    time_reg;
    item_t               item_reg;
    item_t               item_in;
    result_t             res_reg;
    logic                m_valid_reg;

    logic                accept;
    logic                fire;
    logic                rd_en;
    logic                ram_wr_en;
    logic [SET_BITS-1:0] ram_wr_addr;
    logic [ROW_W-1:0]    ram_wr_data;
    logic [ROW_W-1:0]    rd_row;
    logic                lk_wr_en;
    row_t                lk_wr_row;
    result_t             lk_res;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MATE_THR) ? APB_DATA_W'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MATE_THR) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // input unpacking; insert scores are adjusted on the way in
    always_comb begin
        item_in.cmd      = s_tuser;
        item_in.key      = s_tdata[63:0];
        item_in.bound    = s_tdata[81:80];
        item_in.depth    = s_tdata[89:82];
        item_in.ply      = s_tdata[97:90];
        item_in.alpha    = s_tdata[113:98];
        item_in.beta     = s_tdata[129:114];
        item_in.has_move = s_tdata[130];
        item_in.src      = s_tdata[136:131];
        item_in.dest     = s_tdata[142:137];
        item_in.promo    = s_tdata[145:143];
        item_in.score    = mate_adjust(s_tdata[79:64], s_tdata[97:90], thr_reg, 1'b1);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        fire         = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = item_reg.key[SET_BITS-1:0];
        ram_wr_data  = lk_wr_row;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_BITS'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!m_valid_reg || m_tready) begin
                    fire       = 1'b1;
                    ram_wr_en  = lk_wr_en;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (fire && item_reg.cmd == CMD_TICK) begin
            time_reg <= time_reg + 1'b1;
        end
    end

    satt_bucket_ram u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (s_tdata[SET_BITS-1:0]),
        .rd_data (rd_row),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    satt_lookup u_lookup (
        .row      (row_t'(rd_row)),
        .item     (item_reg),
        .time_now (time_reg),
        .thr      (thr_reg),
        .wr_en    (lk_wr_en),
        .wr_row   (lk_wr_row),
        .res      (lk_res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= lk_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

endmodule
`default_nettype wire

/* src/satt_bucket_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// satt_bucket_ram
// one row per bucket holding every way, one write port and one registered read
// ----------------------------------------------------------------------------
module satt_bucket_ram
    import satt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                rd_en,
    input  wire logic [SET_BITS-1:0] rd_addr,
    output logic [ROW_W-1:0]         rd_data,
    input  wire logic                wr_en,
    input  wire logic [SET_BITS-1:0] wr_addr,
    input  wire logic [ROW_W-1:0]    wr_data
);

    logic [ROW_W-1:0] mem [NUM_SETS];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* src/satt_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// satt_lookup
// way match, victim choice, write-back row and probe result for one bucket
// ----------------------------------------------------------------------------
module satt_lookup
    import satt_pkg::*;
(
    input  wire row_t             row,
    input  wire item_t            item,
    input  wire logic [AGE_W-1:0] time_now,
    input  wire logic [THR_W-1:0] thr,
    output logic                  wr_en,
    output row_t                  wr_row,
    output result_t               res
);

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic [15:0]      best;
    logic [15:0]      weight;
    logic [WAY_W-1:0] pick;
    payload_t         hpay;
    payload_t         npay;
    logic signed [SCORE_W-1:0] s_adj;
    logic             depth_ok;

    // lowest matching way, and oldest / shallowest way as the victim
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        victim  = '0;
        best    = {time_now - row[0].pay.stamp, ~row[0].pay.depth};
        weight  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && row[w].key == item.key) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            weight = {time_now - row[w].pay.stamp, ~row[w].pay.depth};
            if (weight > best) begin
                best   = weight;
                victim = WAY_W'(w);
            end
        end
    end

    assign pick = hit ? hit_way : victim;

    always_comb begin
        npay          = '0;
        npay.stamp    = time_now;
        npay.has_move = item.has_move;
        npay.depth    = item.depth;
        npay.bound    = item.bound;
        npay.score    = item.score;
        if (item.has_move) begin
            npay.src   = item.src;
            npay.dest  = item.dest;
            npay.promo = item.promo;
        end
        wr_row           = row;
        wr_row[pick].key = item.key;
        wr_row[pick].pay = npay;
    end

    assign wr_en = (item.cmd == CMD_INSERT);

    assign hpay     = row[hit_way].pay;
    assign s_adj    = mate_adjust(hpay.score, item.ply, thr, 1'b0);
    assign depth_ok = (hpay.depth >= item.depth);

    always_comb begin
        res = '0;
        if (item.cmd == CMD_PROBE && hit) begin
            res.hit = 1'b1;
            if (hpay.has_move) begin
                res.found_move     = 1'b1;
                res.move_src       = hpay.src;
                res.move_dest      = hpay.dest;
                res.move_promotion = hpay.promo;
            end
            if (depth_ok) begin
                unique case (hpay.bound)
                    BOUND_EXACT: begin
                        res.found_score  = 1'b1;
                        res.result_score = s_adj;
                    end
                    BOUND_UPPER: begin
                        if (s_adj <= item.alpha) begin
                            res.found_score  = 1'b1;
                            res.result_score = item.alpha;
                        end
                    end
                    BOUND_LOWER: begin
                        if (s_adj >= item.beta) begin
                            res.found_score  = 1'b1;
                            res.result_score = item.beta;
                        end
                    end
                    default: begin
                        res.found_score = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

/* src/satt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// satt_checker
// port-level checks of the transposition table core
// ----------------------------------------------------------------------------
module satt_checker
    import satt_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [M_DATA_W-1:0]   m_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during lookup");

    // reset starts the clearing pass with input closed
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // flags and score are zero without a hit
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'b00 && m_tdata[18:3] == 16'h0000)
        else $error("result fields set without a hit");

    // returned scores stay inside the legal range
    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[18:3] != 16'h8000)
        else $error("result score out of range");

endmodule

bind set_assoc_transposition_table_core satt_checker u_satt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

/* dv/tt_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tt_monitor
// watches the command, result and register ports of the transposition table,
// keeps its own copy of the buckets, the time counter and the mate threshold,
// works out the response of every accepted command and compares it with the
// result channel in order; register reads are checked against the threshold
// ----------------------------------------------------------------------------
module tt_monitor
    import satt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            s_tuser,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int unsigned           n_errors,
    output int unsigned           n_outstanding
);

    localparam int N_SLOTS    = NUM_SETS * WAYS;
    localparam int REPORT_MAX = 10;
    localparam int SCORE_LIM  = 32767;

    logic [63:0]      slot_key [N_SLOTS];
    payload_t         slot_pay [N_SLOTS];
    logic [AGE_W-1:0] clock_now;
    logic [THR_W-1:0] mate_thr;
    result_t          pending_responses [$];

    function automatic int clamp_score(input int v);
        if (v > SCORE_LIM) begin
            return SCORE_LIM;
        end
        if (v < -SCORE_LIM) begin
            return -SCORE_LIM;
        end
        return v;
    endfunction

    // mate distances move by ply: away from zero when stored, back when read
    function automatic int mate_shift(input int s, input int ply, input bit storing);
        int mag;
        mag = (s < 0) ? -s : s;
        if (mag >= int'(mate_thr)) begin
            if ((s > 0) == storing) begin
                s = s + ply;
            end else begin
                s = s - ply;
            end
        end
        return clamp_score(s);
    endfunction

    function automatic result_t table_apply(input item_t it);
        result_t    r;
        payload_t   p;
        int         base;
        int         pick;
        int         s;
        int         w;
        bit         matched;
        longint     best;
        longint     weight;
        logic [7:0] age;
        r       = '0;
        p       = '0;
        base    = int'(it.key[SET_BITS-1:0]) * WAYS;
        pick    = base;
        matched = 1'b0;
        best    = -(longint'(1) << 40);
        case (it.cmd)
            CMD_INSERT: begin
                for (w = 0; w < WAYS; w++) begin
                    if (!matched) begin
                        if (slot_key[base + w] == it.key) begin
                            pick    = base + w;
                            matched = 1'b1;
                        end else begin
                            age    = clock_now - slot_pay[base + w].stamp;
                            weight = (longint'(age) << 16)
                                     - longint'(slot_pay[base + w].depth);
                            if (weight > best) begin
                                best = weight;
                                pick = base + w;
                            end
                        end
                    end
                end
                p.score = 16'(mate_shift(int'($signed(it.score)), int'(it.ply), 1'b1));
                p.bound = it.bound;
                p.depth = it.depth;
                if (it.has_move) begin
                    p.has_move = 1'b1;
                    p.src      = it.src;
                    p.dest     = it.dest;
                    p.promo    = it.promo;
                end
                p.stamp        = clock_now;
                slot_key[pick] = it.key;
                slot_pay[pick] = p;
            end
            CMD_PROBE: begin
                for (w = 0; w < WAYS; w++) begin
                    if (!matched && slot_key[base + w] == it.key) begin
                        pick    = base + w;
                        matched = 1'b1;
                    end
                end
                if (matched) begin
                    p     = slot_pay[pick];
                    r.hit = 1'b1;
                    if (p.has_move) begin
                        r.found_move     = 1'b1;
                        r.move_src       = p.src;
                        r.move_dest      = p.dest;
                        r.move_promotion = p.promo;
                    end
                    if (p.depth >= it.depth) begin
                        s = mate_shift(int'($signed(p.score)), int'(it.ply), 1'b0);
                        case (p.bound)
                            BOUND_EXACT: begin
                                r.found_score  = 1'b1;
                                r.result_score = 16'(s);
                            end
                            BOUND_UPPER: begin
                                if (s <= int'($signed(it.alpha))) begin
                                    r.found_score  = 1'b1;
                                    r.result_score = it.alpha;
                                end
                            end
                            BOUND_LOWER: begin
                                if (s >= int'($signed(it.beta))) begin
                                    r.found_score  = 1'b1;
                                    r.result_score = it.beta;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            CMD_TICK: begin
                clock_now = clock_now + 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("hit=%0d move=%0d found=%0d score=%0d src=%0d dest=%0d promo=%0d",
                         r.hit, r.found_move, r.found_score, r.result_score,
                         r.move_src, r.move_dest, r.move_promotion);
    endfunction

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        item_t   cmd_in;
        if (!aresetn) begin
            foreach (slot_key[i]) begin
                slot_key[i] = '0;
                slot_pay[i] = '0;
            end
            clock_now = '0;
            mate_thr  = THR_RESET;
            pending_responses.delete();
            n_errors      = 0;
            n_outstanding = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (pending_responses.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX) begin
                        $display("%0t: result transaction with none pending: %s",
                                 $realtime, fmt_result(got));
                    end
                end else begin
                    want = pending_responses.pop_front();
                    if (got.hit !== want.hit || got.found_move !== want.found_move
                        || got.found_score !== want.found_score
                        || got.result_score !== want.result_score
                        || got.move_src !== want.move_src
                        || got.move_dest !== want.move_dest
                        || got.move_promotion !== want.move_promotion) begin
                        n_errors++;
                        if (n_errors <= REPORT_MAX) begin
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, fmt_result(want), fmt_result(got));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                cmd_in.cmd = s_tuser;
                {cmd_in.promo, cmd_in.dest, cmd_in.src, cmd_in.has_move, cmd_in.beta,
                 cmd_in.alpha, cmd_in.ply, cmd_in.depth, cmd_in.bound, cmd_in.score,
                 cmd_in.key} = s_tdata[145:0];
                pending_responses.push_back(table_apply(cmd_in));
            end
            if (psel && penable && pready && (paddr >> 2) == REG_MATE_THR) begin
                if (pwrite) begin
                    mate_thr = pwdata[THR_W-1:0];
                end else if (prdata !== APB_DATA_W'(mate_thr)) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX) begin
                        $display("%0t: threshold read mismatch: expected %0d actual %0d",
                                 $realtime, mate_thr, prdata);
                    end
                end
            end
            n_outstanding = pending_responses.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives insert, probe and tick commands into the transposition table core:
// a directed opening on the cleared table, then random phases over a small
// pool of colliding keys, each under a different mate threshold; bursty
// sender, stalling receiver with one long hold-off, idle watchdog
// ----------------------------------------------------------------------------
module tb;
    import satt_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 140;
    localparam int HOLD_AT      = 230;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int POOL_SIZE    = 32;
    localparam int HOT_BUCKETS  = 4;

    localparam logic [1:0]            CMD_NOP     = 2'd3;
    localparam logic [1:0]            BOUND_NONE  = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_THR    = {REG_MATE_THR, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    typedef enum int {
        SINK_OPEN,
        SINK_HALF,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [1:0]            s_tuser  = '0;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned      n_errors;
    int unsigned      n_outstanding;
    int               n_sent      = 0;
    int               burst_left  = 0;
    int               idle_cycles = 0;
    logic [THR_W-1:0] thr_now     = THR_RESET;
    logic [63:0]      key_pool [POOL_SIZE];

    set_assoc_transposition_table_core i_dut (.*);

    tt_monitor i_monitor (.*);

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL set_assoc_transposition_table_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic item_t mk(input logic [1:0] cmd, input logic [63:0] key,
                                 input int score, input logic [1:0] bound, input int depth,
                                 input int ply, input int alpha, input int beta,
                                 input bit mv, input int src, input int dst, input int pro);
        item_t it;
        it.cmd      = cmd;
        it.key      = key;
        it.score    = 16'(score);
        it.bound    = bound;
        it.depth    = 8'(depth);
        it.ply      = 8'(ply);
        it.alpha    = 16'(alpha);
        it.beta     = 16'(beta);
        it.has_move = mv;
        it.src      = 6'(src);
        it.dest     = 6'(dst);
        it.promo    = 3'(pro);
        return it;
    endfunction

    // uniform, around the mate threshold, the extremes, or near zero
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int v;
        case ($urandom_range(0, 4))
            0: v = int'($urandom_range(0, 65534)) - 32767;
            1: v = int'(thr_now) + int'($urandom_range(0, 6)) - 3;
            2: v = -(int'(thr_now) + int'($urandom_range(0, 6)) - 3);
            3: v = $urandom_range(0, 1) ? 32767 : -32767;
            default: v = int'($urandom_range(0, 400)) - 200;
        endcase
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32767) begin
            v = -32767;
        end
        return 16'(v);
    endfunction

    function automatic item_t rand_item(input int tick_pct);
        item_t it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            it.cmd = CMD_TICK;
        end else if (r < tick_pct + 3) begin
            it.cmd = CMD_NOP;
        end else begin
            it.cmd = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_PROBE;
        end
        r = $urandom_range(0, 99);
        if (r < 85) begin
            it.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 90) begin
            it.key = '0;
        end else begin
            it.key = {$urandom, $urandom};
        end
        it.score    = pick_score();
        it.bound    = ($urandom_range(0, 19) == 0) ? BOUND_NONE : 2'($urandom_range(0, 2));
        it.depth    = $urandom_range(0, 1) ? 8'($urandom_range(0, 12)) : 8'($urandom);
        it.ply      = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
        it.alpha    = pick_score();
        it.beta     = pick_score();
        it.has_move = 1'($urandom);
        it.src      = 6'($urandom);
        it.dest     = 6'($urandom);
        it.promo    = 3'($urandom);
        return it;
    endfunction

    // bursts of random length, random gaps between them, now and then a long run
    task automatic offer(input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'b0, it.promo, it.dest, it.src, it.has_move, it.beta, it.alpha,
                     it.ply, it.depth, it.bound, it.score, it.key};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        wait (n_outstanding == 0);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        drain();
        apb_access(1'b1, ADDR_THR, {17'($urandom), value});
        thr_now = value;
        apb_access(1'b0, ADDR_THR, '0);
    endtask

    initial begin : result_sink
        sink_mode_t mode;
        int         left;
        int         k;
        bit         held;
        left = 0;
        k    = 0;
        held = 1'b0;
        mode = SINK_OPEN;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                mode = sink_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 120);
            end
            left--;
            k++;
            case (mode)
                SINK_OPEN:     m_tready <= 1'b1;
                SINK_HALF:     m_tready <= 1'($urandom);
                SINK_SPARSE:   m_tready <= ($urandom_range(0, 4) == 0);
                SINK_PERIODIC: m_tready <= (k % 3 != 0);
            endcase
        end
    end

    initial begin : stimulus
        logic [63:0]      kx [5];
        logic [9:0]       hot [HOT_BUCKETS];
        logic [9:0]       dbucket;
        logic [THR_W-1:0] thr_plan [N_PHASES];
        int               tick_pct [N_PHASES];
        int               i;
        int               p;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // colliding pool: most keys share a handful of buckets, bucket 0 included
        hot[0] = '0;
        for (i = 1; i < HOT_BUCKETS; i++) begin
            hot[i] = 10'($urandom);
        end
        for (i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][SET_BITS-1:0] = hot[i % HOT_BUCKETS];
        end
        key_pool[POOL_SIZE - 1] = '1;

        dbucket = 10'($urandom_range(1, 1022));
        for (i = 0; i < 5; i++) begin
            kx[i] = {$urandom, $urandom};
            kx[i][63:60] = 4'(i + 1);
            kx[i][SET_BITS-1:0] = dbucket;
        end

        // cleared table: key zero hits an empty exact entry
        offer(mk(CMD_PROBE, '0, 0, BOUND_EXACT, 0, 0, -32767, 32767, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, '0, 0, BOUND_EXACT, 1, 0, -32767, 32767, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[0], 0, BOUND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(mk(CMD_INSERT, kx[0], 29999, BOUND_EXACT, 255, 255, 0, 0, 1, 63, 63, 7));
        offer(mk(CMD_PROBE, kx[0], 0, BOUND_EXACT, 255, 255, -32767, 32767, 0, 0, 0, 0));
        // move fields dropped when no move is stored
        offer(mk(CMD_INSERT, kx[1], 32767, BOUND_LOWER, 0, 200, 0, 0, 0, 63, 63, 7));
        offer(mk(CMD_PROBE, kx[1], 0, BOUND_EXACT, 0, 0, 0, 32767, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[1], 0, BOUND_EXACT, 0, 255, 0, -32767, 0, 0, 0, 0));
        offer(mk(CMD_INSERT, kx[2], -32767, BOUND_UPPER, 8, 17, 0, 0, 1, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[2], 0, BOUND_EXACT, 8, 0, 32767, 0, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[2], 0, BOUND_EXACT, 0, 0, -32767, 0, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[2], 0, BOUND_EXACT, 9, 0, 32767, 0, 0, 0, 0, 0));
        // unusable bound code
        offer(mk(CMD_INSERT, kx[3], 100, BOUND_NONE, 3, 0, 0, 0, 1, 21, 42, 5));
        offer(mk(CMD_PROBE, kx[3], 0, BOUND_EXACT, 0, 0, 32767, -32767, 0, 0, 0, 0));
        offer(mk(CMD_TICK, '1, -32767, BOUND_NONE, 255, 255, 32767, -32767, 1, 63, 63, 7));
        offer(mk(CMD_NOP, '1, 32767, BOUND_NONE, 255, 255, -32767, 32767, 1, 63, 63, 7));
        // full bucket: oldest and shallowest way goes
        offer(mk(CMD_INSERT, kx[4], 5, BOUND_EXACT, 1, 0, 0, 0, 1, 1, 2, 3));
        offer(mk(CMD_PROBE, kx[0], 0, BOUND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[1], 0, BOUND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(mk(CMD_INSERT, '0, 30000, BOUND_EXACT, 4, 10, 0, 0, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, '0, 0, BOUND_EXACT, 4, 10, 0, 0, 0, 0, 0, 0));
        offer(mk(CMD_INSERT, '1, -30000, BOUND_LOWER, 255, 50, 0, 0, 1, 21, 42, 5));
        offer(mk(CMD_PROBE, '1, 0, BOUND_EXACT, 255, 3, 0, -32767, 0, 0, 0, 0));
        offer(mk(CMD_INSERT, kx[4], 0, BOUND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(mk(CMD_PROBE, kx[4], 0, BOUND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));

        thr_plan[0] = '0;
        thr_plan[1] = 15'd32767;
        thr_plan[2] = 15'($urandom);
        thr_plan[3] = 15'd1;
        thr_plan[4] = THR_RESET;
        tick_pct[0] = 15;
        tick_pct[1] = 70;
        tick_pct[2] = 15;
        tick_pct[3] = 70;
        tick_pct[4] = 15;

        for (p = 0; p < N_PHASES; p++) begin
            set_threshold(thr_plan[p]);
            if (p == 0) begin
                apb_access(1'b1, ADDR_UNUSED, $urandom);
                apb_access(1'b0, ADDR_THR, '0);
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                offer(rand_item(tick_pct[p]));
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("PASS set_assoc_transposition_table_core");
        end else begin
            $display("FAIL set_assoc_transposition_table_core");
        end
        $finish;
    end

endmodule
